[src/las_pkg.sv]
// Shared constants, types and functions of the life automaton stencil.
`timescale 1ns / 1ps
package las_pkg;

	localparam int ROW_WIDTH   = 1024;
	localparam int ROW_BANKS   = 3;
	localparam int COL_W       = $clog2(ROW_WIDTH);
	localparam int BANK_W      = 2;
	localparam int ROW_W       = 12;
	localparam int CFG_W       = 11;
	localparam int ROWS_MAX    = 4095;
	localparam int COL_CAP     = 1024;
	localparam int MIN_COLS    = 3;
	localparam int FIFO_DEPTH  = 8;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
	localparam int MAX_RESULTS = 3;

	localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(COL_CAP);

	typedef struct packed {
		logic ovr_val;
		logic ovr;
		logic alive;
	} entry_t;

	typedef entry_t [ROW_BANKS-1:0] bank_rd_t;

	typedef struct packed {
		entry_t old_e;
		entry_t mid_e;
		entry_t new_e;
	} column_t;

	typedef struct packed {
		logic             next_alive;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_column;
		logic             row_done;
	} result_t;

	typedef result_t [MAX_RESULTS-1:0] result_set_t;

	typedef enum logic [1:0] {
		FS_IDLE = 2'b01,
		FS_FILL = 2'b10
	} fill_state_t;

	function automatic logic [BANK_W-1:0] bank_add(input logic [BANK_W-1:0] b,
		input logic [BANK_W-1:0] k);
		logic [BANK_W:0] s;
		s = {1'b0, b} + {1'b0, k};
		if (s >= (BANK_W+1)'(ROW_BANKS)) begin
			s = s - (BANK_W+1)'(ROW_BANKS);
		end
		return s[BANK_W-1:0];
	endfunction

	// B3/S23 rule on a 3x3 neighborhood; the middle cell's override wins.
	function automatic logic life_rule(input column_t lf, input column_t cx,
		input column_t rt);
		logic [3:0] cnt;
		logic       nxt;
		cnt = 4'(lf.old_e.alive) + 4'(cx.old_e.alive) + 4'(rt.old_e.alive)
			+ 4'(lf.mid_e.alive) + 4'(rt.mid_e.alive)
			+ 4'(lf.new_e.alive) + 4'(cx.new_e.alive) + 4'(rt.new_e.alive);
		if (cx.mid_e.ovr) begin
			nxt = cx.mid_e.ovr_val;
		end else if (cx.mid_e.alive) begin
			nxt = (cnt == 4'd2) || (cnt == 4'd3);
		end else begin
			nxt = (cnt == 4'd3);
		end
		return nxt;
	endfunction

endpackage

[src/las_ifs.sv]
// Handshake interfaces for the cell, result and configuration channels.
`timescale 1ns / 1ps
interface las_cell_if;
	logic valid;
	logic ready;
	logic cell_alive;
	logic random_override;
	logic override_value;
	logic frame_start;

	modport source(output valid, cell_alive, random_override, override_value,
		frame_start, input ready);
	modport sink(input valid, cell_alive, random_override, override_value,
		frame_start, output ready);
endinterface

interface las_result_if;
	logic        valid;
	logic        ready;
	logic        next_alive;
	logic [11:0] out_row;
	logic [9:0]  out_column;
	logic        row_done;

	modport source(output valid, next_alive, out_row, out_column, row_done,
		input ready);
	modport sink(input valid, next_alive, out_row, out_column, row_done,
		output ready);
endinterface

interface las_cfg_if;
	logic        valid;
	logic        ready;
	logic [10:0] active_columns;

	modport source(output valid, active_columns, input ready);
	modport sink(input valid, active_columns, output ready);
endinterface

[src/las_line_store.sv]
// Three row banks of cell entries with one write and a registered read of all banks.
`timescale 1ns / 1ps
module las_line_store (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [las_pkg::BANK_W-1:0]   wr_bank,
	input  logic [las_pkg::COL_W-1:0]    wr_addr,
	input  las_pkg::entry_t              wr_data,
	input  logic                         rd_en,
	input  logic [las_pkg::COL_W-1:0]    rd_addr,
	output las_pkg::bank_rd_t            rd_data
);
	import las_pkg::*;

	for (genvar b = 0; b < ROW_BANKS; b++) begin : g_bank
		entry_t mem [ROW_WIDTH];
		entry_t rd_q;

		always_ff @(posedge clk) begin
			if (wr_en && (wr_bank == BANK_W'(b))) begin
				mem[wr_addr] <= wr_data;
			end
			if (rd_en) begin
				rd_q <= mem[rd_addr];
			end
		end

		assign rd_data[b] = rd_q;
	end

endmodule

[src/las_result_fifo.sv]
// Result queue that takes up to three words a cycle and hands out one.
`timescale 1ns / 1ps
module las_result_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    push_cnt,
	input  las_pkg::result_set_t          push_data,
	output logic [las_pkg::FIFO_CNT_W-1:0] count,
	las_result_if.source                  result
);
	import las_pkg::*;

	result_t               mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	assign pop = result.valid && result.ready;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (2'(i) < push_cnt) begin
				mem[wr_ptr_q + FIFO_PTR_W'(i)] <= push_data[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
		end
	end

	assign count             = count_q;
	assign result.valid      = (count_q != '0);
	assign result.next_alive = mem[rd_ptr_q].next_alive;
	assign result.out_row    = mem[rd_ptr_q].out_row;
	assign result.out_column = mem[rd_ptr_q].out_column;
	assign result.row_done   = mem[rd_ptr_q].row_done;

endmodule

[src/life_automaton_stencil.sv]
// Top level of the streaming B3/S23 life stencil.
`timescale 1ns / 1ps
// The block takes one cell word per cycle when ready, in raster order, and returns
// the next generation of the row above through the input-stage registers and the
// result queue. From the third row on, every cell from the third column on gives
// one result word and the last cell of a row gives three. The first two cells of
// the next row give none, so an eight-word result queue absorbs the two extra words
// and the cell side keeps one word a cycle while the result side takes one word a
// cycle; ready drops when the result side holds off and the queue could overflow,
// and during a reload. A sliding 3x3 window fed by the three-bank line store and
// two saved wrap columns supplies the neighbors. From the third row on, a mid-row
// narrowing below the current column makes the next cell wait while the window
// reloads from the line store. The line store needs no clearing after reset.
module life_automaton_stencil (
	input  logic          clk,
	input  logic          arst_n,
	las_cell_if.sink      cells,
	las_result_if.source  result,
	las_cfg_if.sink       cfg
);
	import las_pkg::*;

	logic [CFG_W-1:0]      active_q;
	logic [COL_W-1:0]      col_cnt_q;
	logic [ROW_W-1:0]      rows_seen_q;
	logic [BANK_W-1:0]     nb_q;
	fill_state_t           fs_q;
	logic                  fill_done_q;

	logic [COL_W-1:0]      nm1;
	logic [COL_W-1:0]      col_eff;
	logic [ROW_W-1:0]      rows_eff;
	logic                  sat;
	logic [COL_W-1:0]      c;
	logic                  last;
	logic                  emit;
	logic                  need_fill;
	logic                  room;
	logic                  accept;
	logic                  fill_rd;
	logic                  rd_en;
	logic [COL_W-1:0]      rd_addr;
	entry_t                in_entry;
	bank_rd_t              rd_data;

	logic                  v_s1;
	logic                  real_s1;
	logic                  ea_s1;
	logic                  el_s1;
	entry_t                new_s1;
	logic [COL_W-1:0]      c_s1;
	logic [COL_W-1:0]      nm1_s1;
	logic [ROW_W-1:0]      row_s1;
	logic [BANK_W-1:0]     nb_s1;
	logic                  cap0_s1;
	logic                  cap1_s1;

	column_t               w2_q;
	column_t               w1_q;
	column_t               col0_q;
	column_t               col1_q;
	column_t               cur;
	result_t               ra;
	result_t               rb;
	result_t               rc;
	result_set_t           push_data;
	logic [1:0]            push_cnt;
	logic [1:0]            k_s1;
	logic [FIFO_CNT_W-1:0] fifo_count;

	// Effective width minus one, held to the supported range.
	always_comb begin
		if (active_q < CFG_W'(MIN_COLS)) begin
			nm1 = COL_W'(MIN_COLS - 1);
		end else if (active_q > CFG_W'(COL_CAP)) begin
			nm1 = COL_W'(COL_CAP - 1);
		end else begin
			nm1 = COL_W'(active_q - CFG_W'(1));
		end
	end

	assign col_eff  = cells.frame_start ? '0 : col_cnt_q;
	assign rows_eff = cells.frame_start ? '0 : rows_seen_q;
	assign sat      = (col_eff > nm1);
	assign c        = sat ? nm1 : col_eff;
	assign last     = (c == nm1);
	assign emit     = (rows_eff >= ROW_W'(2));

	assign need_fill = cells.valid && !cells.frame_start && (col_cnt_q > nm1)
		&& (rows_seen_q >= ROW_W'(2)) && !fill_done_q;

	assign k_s1 = {el_s1, ea_s1};
	assign room = (fifo_count + FIFO_CNT_W'(k_s1)) <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS);

	assign cells.ready = (fs_q == FS_IDLE) && !need_fill && room;
	assign accept      = cells.valid && cells.ready;
	assign fill_rd     = ((fs_q == FS_IDLE) && need_fill) || (fs_q == FS_FILL);

	assign rd_en = accept || fill_rd;
	always_comb begin
		if (fs_q == FS_FILL) begin
			rd_addr = nm1 - COL_W'(1);
		end else if (fill_rd) begin
			rd_addr = nm1 - COL_W'(2);
		end else begin
			rd_addr = c;
		end
	end

	assign in_entry = '{ovr_val: cells.override_value, ovr: cells.random_override,
		alive: cells.cell_alive};

	las_line_store u_store (
		.clk     (clk),
		.wr_en   (accept),
		.wr_bank (nb_q),
		.wr_addr (c),
		.wr_data (in_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= ACTIVE_RESET;
			col_cnt_q   <= '0;
			rows_seen_q <= '0;
			nb_q        <= '0;
			fs_q        <= FS_IDLE;
			fill_done_q <= 1'b0;
			v_s1        <= 1'b0;
			real_s1     <= 1'b0;
			ea_s1       <= 1'b0;
			el_s1       <= 1'b0;
		end else begin
			if (cfg.valid) begin
				active_q <= cfg.active_columns;
			end
			unique case (fs_q)
				FS_IDLE: begin
					if (need_fill) begin
						fs_q <= FS_FILL;
					end
				end
				FS_FILL: begin
					fs_q        <= FS_IDLE;
					fill_done_q <= 1'b1;
				end
				default: fs_q <= FS_IDLE;
			endcase
			if (accept) begin
				fill_done_q <= 1'b0;
				if (last) begin
					col_cnt_q <= '0;
					nb_q      <= bank_add(nb_q, BANK_W'(1));
					if (rows_eff < ROW_W'(ROWS_MAX)) begin
						rows_seen_q <= rows_eff + ROW_W'(1);
					end else begin
						rows_seen_q <= rows_eff;
					end
				end else begin
					col_cnt_q   <= c + COL_W'(1);
					rows_seen_q <= rows_eff;
				end
			end
			v_s1    <= accept || fill_rd;
			real_s1 <= accept;
			ea_s1   <= accept && emit && (c >= COL_W'(2));
			el_s1   <= accept && emit && last;
		end
	end

	always_ff @(posedge clk) begin
		new_s1  <= in_entry;
		c_s1    <= c;
		nm1_s1  <= nm1;
		row_s1  <= rows_eff - ROW_W'(2);
		nb_s1   <= nb_q;
		cap0_s1 <= (c == '0);
		cap1_s1 <= (c == COL_W'(1));
	end

	// Column now entering the window: old and middle rows come from the store,
	// the newest row from the cell word itself or, on a reload, from the store.
	always_comb begin
		cur.old_e = rd_data[bank_add(nb_s1, BANK_W'(1))];
		cur.mid_e = rd_data[bank_add(nb_s1, BANK_W'(2))];
		cur.new_e = real_s1 ? new_s1 : rd_data[nb_s1];
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			w2_q <= w1_q;
			w1_q <= cur;
			if (real_s1 && cap0_s1) begin
				col0_q <= cur;
			end
			if (real_s1 && cap1_s1) begin
				col1_q <= cur;
			end
		end
	end

	assign ra = '{next_alive: life_rule(w2_q, w1_q, cur), out_row: row_s1,
		out_column: c_s1 - COL_W'(1), row_done: 1'b0};
	assign rb = '{next_alive: life_rule(w1_q, cur, col0_q), out_row: row_s1,
		out_column: nm1_s1, row_done: 1'b0};
	assign rc = '{next_alive: life_rule(cur, col0_q, col1_q), out_row: row_s1,
		out_column: '0, row_done: 1'b1};

	always_comb begin
		push_data[0] = ea_s1 ? ra : rb;
		push_data[1] = ea_s1 ? rb : rc;
		push_data[2] = rc;
		push_cnt     = k_s1;
	end

	las_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push_data (push_data),
		.count     (fifo_count),
		.result    (result)
	);

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("result queue holds more words than its depth");

	a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(fs_q == FS_FILL) |-> !accept)
		else $error("cell word accepted during a window reload");

	a_bank_range: assert property (@(posedge clk) disable iff (!arst_n)
		nb_q != 2'd3)
		else $error("newest bank index out of range");

	a_fill_then_accept_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(fs_q == FS_FILL) |=> fill_done_q && (fs_q == FS_IDLE))
		else $error("window reload did not complete");

	a_done_col0: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) && el_s1 |-> push_data[push_cnt - 2'd1].row_done)
		else $error("row end without row_done on its last word");

endmodule
